[rtl/tsba_pkg.sv]
// tsba_pkg: shared types, constants and helpers of the tiered split block allocator
package tsba_pkg;

  localparam int PAGE_GRANULES = 16;
  localparam int MAX_PAGES     = 1024;
  localparam int LEVELS        = 5;

  localparam int ADDR_W     = 14;
  localparam int LVL_IN_W   = 3;
  localparam int END_W      = 15;
  localparam int LIM_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_GRANULES);
  localparam int LINK_DEPTH = 1 << ADDR_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SPLIT
  } eng_state_t;

  // one classified request between front and back
  typedef struct packed {
    req_kind_t           kind;
    logic [IDX_W-1:0]    lvl;
    logic [ADDR_W-1:0]   block_addr;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
  } res_t;

  // handshake between front queue and engine
  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

  // block size of a tier in granules, never below one
  function automatic logic [ADDR_W-1:0] tier_size(input logic [IDX_W-1:0] k);
    logic [ADDR_W-1:0] s;
    s = ADDR_W'(PAGE_GRANULES) >> k;
    if (s == '0) begin
      s = ADDR_W'(1);
    end
    return s;
  endfunction

endpackage

[rtl/tsba_ram.sv]
// tsba_ram: generic simple dual-port ram with registered read
module tsba_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tsba_front.sv]
// tsba_front: input queue that accepts items and classifies their tier
module tsba_front import tsba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_req_type,
  input  logic [LVL_IN_W-1:0] in_level,
  input  logic [ADDR_W-1:0]   in_block_addr,
  output logic                in_full,
  output req_chan_t           req_ch,
  input  logic                req_take
);

  req_t        q_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  req_t        cls;
  logic        do_push, do_pop;

  // tiers beyond the last one saturate
  always_comb begin
    cls.kind       = req_kind_t'(in_req_type);
    cls.block_addr = in_block_addr;
    if (in_level >= LVL_IN_W'(LEVELS)) begin
      cls.lvl = IDX_W'(LEVELS - 1);
    end else begin
      cls.lvl = in_level[IDX_W-1:0];
    end
  end

  assign in_full  = (cnt_r == 2'd2);
  assign do_push  = in_push && !in_full;
  assign do_pop   = req_take && (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls;
    end
  end

  assign req_ch.valid = (cnt_r != 2'd0);
  assign req_ch.req   = q_r[rp_r];

endmodule

[rtl/tsba_engine.sv]
// tsba_engine: free-list heads, split sequencer, link memory and result queue
module tsba_engine import tsba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [LIM_W-1:0]    cfg_page_limit,
  input  req_chan_t           req_ch,
  output logic                req_take,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_addr
);

  eng_state_t         st_r, st_nxt;
  logic [ADDR_W-1:0]  heads_r [LEVELS];
  logic [ADDR_W-1:0]  heads_nxt [LEVELS];
  logic [END_W-1:0]   end_r, end_nxt;
  logic [LIM_W-1:0]   limit_r;
  logic [IDX_W-1:0]   lvl_r, lvl_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [ADDR_W-1:0]  blk_r, blk_nxt;

  // link memory ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // result queue
  res_t               oq_r [2];
  logic               oq_wp_r, oq_rp_r;
  logic [1:0]         oq_cnt_r;
  logic               res_push, oq_pop;
  res_t               res;

  logic [IDX_W-1:0]   jsel;
  logic               hit;
  logic [LIM_W-1:0]   lim;
  logic [END_W:0]     page_end;
  logic [END_W:0]     page_cap;
  logic [ADDR_W-1:0]  upper;
  logic [ADDR_W-1:0]  tmask;

  tsba_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LINK_DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // nearest tier at or above the request with a free block
  always_comb begin
    jsel = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((IDX_W'(i) <= req_ch.req.lvl) && (heads_r[i] != '0)) begin
        jsel = IDX_W'(i);
      end
    end
    hit = (heads_r[jsel] != '0);
  end

  always_comb begin
    lim      = (limit_r > LIM_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES) : limit_r;
    page_end = {1'b0, end_r} + (END_W+1)'(PAGE_GRANULES);
    page_cap = (END_W+1)'(lim) << PAGE_SHIFT;
    upper    = blk_r + tier_size(k_r);
    tmask    = tier_size(j_r) - ADDR_W'(1);
  end

  always_comb begin
    st_nxt    = st_r;
    end_nxt   = end_r;
    lvl_nxt   = lvl_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    blk_nxt   = blk_r;
    for (int i = 0; i < LEVELS; i++) begin
      heads_nxt[i] = heads_r[i];
    end
    req_take  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = blk_r;
    ram_wdata = '0;
    ram_raddr = heads_r[jsel];
    res_push  = 1'b0;
    res.status = ST_OK;
    res.addr   = blk_r;

    case (st_r)
      S_IDLE: begin
        if (req_ch.valid && (oq_cnt_r != 2'd2)) begin
          req_take = 1'b1;
          lvl_nxt  = req_ch.req.lvl;
          if (req_ch.req.kind == REQ_FREE) begin
            ram_we    = 1'b1;
            ram_waddr = req_ch.req.block_addr;
            ram_wdata = heads_r[req_ch.req.lvl];
            heads_nxt[req_ch.req.lvl] = req_ch.req.block_addr;
            res_push  = 1'b1;
            res.addr  = req_ch.req.block_addr;
          end else if (hit) begin
            // link of the popped block arrives next cycle
            j_nxt   = jsel;
            blk_nxt = heads_r[jsel];
            st_nxt  = S_CHECK;
          end else if (page_end > page_cap) begin
            res_push   = 1'b1;
            res.status = ST_FULL;
            res.addr   = '0;
          end else begin
            end_nxt = page_end[END_W-1:0];
            blk_nxt = end_r[ADDR_W-1:0];
            if (req_ch.req.lvl == '0) begin
              res_push = 1'b1;
              res.addr = end_r[ADDR_W-1:0];
            end else begin
              k_nxt  = IDX_W'(1);
              st_nxt = S_SPLIT;
            end
          end
        end
      end

      S_CHECK: begin
        if ((ram_rdata & tmask) != '0) begin
          res_push   = 1'b1;
          res.status = ST_CORRUPT;
          res.addr   = '0;
          st_nxt     = S_IDLE;
        end else begin
          heads_nxt[j_r] = ram_rdata;
          if (j_r == lvl_r) begin
            res_push = 1'b1;
            st_nxt   = S_IDLE;
          end else begin
            k_nxt  = j_r + IDX_W'(1);
            st_nxt = S_SPLIT;
          end
        end
      end

      S_SPLIT: begin
        // upper half goes on this tier's list as its only entry
        heads_nxt[k_r] = upper;
        ram_we    = 1'b1;
        ram_waddr = upper;
        ram_wdata = '0;
        if (k_r == lvl_r) begin
          res_push = 1'b1;
          st_nxt   = S_IDLE;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      end_r   <= END_W'(PAGE_GRANULES);
      limit_r <= LIM_W'(1024);
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      st_r  <= st_nxt;
      end_r <= end_nxt;
      if (cfg_we) begin
        limit_r <= cfg_page_limit;
      end
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i] <= heads_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    blk_r <= blk_nxt;
  end

  // two-entry result queue so the engine keeps going while a result waits
  assign oq_pop = out_pop && (oq_cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wp_r <= ~oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= ~oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + {1'b0, res_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wp_r] <= res;
    end
  end

  assign out_empty  = (oq_cnt_r == 2'd0);
  assign out_status = oq_r[oq_rp_r].status;
  assign out_addr   = oq_r[oq_rp_r].addr;

endmodule

[rtl/tiered_split_block_allocator.sv]
// tiered_split_block_allocator: top level of the five-tier block allocator
//
// Input channel: drive in_req_type, in_level, in_block_addr and raise in_push;
// the item is taken at a clock edge where in_full is low. A two-entry queue
// holds items until the allocation engine picks them up.
// Result channel: while out_empty is low, out_status and out_addr show the
// oldest result; raising out_pop takes it. Each item yields exactly one result.
// Configuration: cfg_we writes cfg_page_limit; the user must do so only while
// the block is idle, which the block itself does not enforce. The engine
// handles a free or a fresh page for tier 0 in its idle state alone; a block
// that comes off a free list adds a check state (link memory read), and each
// tier split below the source tier adds a split state with one link write.
// A result is registered in the output queue before it shows on the outputs,
// and an item passes through the registered input queue to reach the engine.
// When the receiver stalls, up to two results wait in the output queue, then
// the engine holds and the input queue fills and raises in_full.
// Reset (synchronous, rst_n low) empties both queues and all free lists and
// sets the end pointer to the first page; link memory is not cleared.
module tiered_split_block_allocator import tsba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_req_type,
  input  logic [LVL_IN_W-1:0] in_level,
  input  logic [ADDR_W-1:0]   in_block_addr,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_addr,
  input  logic                cfg_we,
  input  logic [LIM_W-1:0]    cfg_page_limit
);

  req_chan_t req_ch;
  logic      req_take;

  tsba_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_req_type   (in_req_type),
    .in_level      (in_level),
    .in_block_addr (in_block_addr),
    .in_full       (in_full),
    .req_ch        (req_ch),
    .req_take      (req_take)
  );

  tsba_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_page_limit (cfg_page_limit),
    .req_ch         (req_ch),
    .req_take       (req_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_addr       (out_addr)
  );

  // engine never takes from an empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> req_ch.valid)
    else $error("engine took a request from an empty queue");

  // a free finishes in the same cycle that the engine takes it
  a_free_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && req_ch.req.kind == REQ_FREE) |=> !out_empty)
    else $error("free result did not appear");

  // failed requests report a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> out_addr == '0)
    else $error("failed request carries an address");

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
